[rtl/core/conv2d_3x3_same_stream_defines.svh]
// ----------------------------------------------------------------------------
// conv2d_3x3_same_stream_defines.svh
// Assertion macros for the 3x3 convolution checker.
// ----------------------------------------------------------------------------
`ifndef CONV2D_3X3_SAME_STREAM_DEFINES_SVH
`define CONV2D_3X3_SAME_STREAM_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define C2D_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define C2D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/c2d_pkg.sv]
// ----------------------------------------------------------------------------
// c2d_pkg
// Types and fixed constants of the streaming 3x3 same-size convolution.
// ----------------------------------------------------------------------------
`default_nettype none

package c2d_pkg;

   localparam int KERNEL_SIZE      = 3;
   localparam int WEIGHT_BITS      = 16;
   localparam int SUM_BITS         = 35;
   localparam int POS_BITS         = 5;
   localparam int IMAGE_WIDTH_BITS = 6;
   localparam int KERNEL_ROW_BITS  = 48;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int MIN_WIDTH        = 3;
   // result queue depth, power of two, covers the pipeline plus slack
   localparam int OUT_DEPTH        = 8;

   localparam logic [IMAGE_WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = 6'd32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_KERNEL_TOP    = 2'd1,
      CSR_KERNEL_MID    = 2'd2,
      CSR_KERNEL_BOTTOM = 2'd3
   } csr_index_type;

   typedef enum logic {
      SEQ_RUN,
      SEQ_FLUSH
   } seq_state_type;

   // one column step through the window datapath
   typedef struct packed {
      logic                emit;
      logic                top_clear;
      logic                bot_clear;
      logic                zero_third;
      logic                col_start;
      logic                mem_write;
      logic                virt;
      logic                run_last;
      logic                frame_last;
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
   } step_type;

   typedef struct packed {
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
      logic                run_last;
      logic                frame_last;
   } pos_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      pos_type                    pos;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/conv2d_3x3_same_stream.sv]
// ----------------------------------------------------------------------------
// conv2d_3x3_same_stream
// Streaming 3x3 cross-correlation, one pixel of zero padding, same-size out.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+-------------------------------------
//  req_    | in  | valid / stall       | pixel, raster order
//  rsp_    | out | valid / stall       | conv_sum, out_row, out_col, lasts
//  csr_    | in  | valid / ready       | index, data (ready tied high)
//
//  One input word per cycle while not stalled. Result words pass through
//  pipeline stages 1 to 3 and then through an 8-entry output queue.
//  After the last pixel of a frame, input is held off while the
//  bottom output row is rebuilt from the single read port of the line store.
//  Input stalls whenever the queue plus in-flight results would overflow.
//  Synchronous active-high reset; the line store needs no clearing pass.
//
`default_nettype none

module conv2d_3x3_same_stream #(
   parameter int MAX_WIDTH   = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // input pixels
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [SAMPLE_BITS-1:0]             req_pixel,
   // results
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [c2d_pkg::SUM_BITS-1:0]       rsp_conv_sum,
   output logic [c2d_pkg::POS_BITS-1:0]              rsp_out_row,
   output logic [c2d_pkg::POS_BITS-1:0]              rsp_out_col,
   output logic                                      rsp_run_last,
   output logic                                      rsp_frame_last,
   // configuration writes
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [c2d_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [c2d_pkg::KERNEL_ROW_BITS-1:0]       csr_data
);

   localparam int CW    = $clog2(MAX_WIDTH + 1);   // holds 0..MAX_WIDTH
   localparam int AW    = $clog2(MAX_WIDTH);       // line store address
   localparam int KS    = c2d_pkg::KERNEL_SIZE;
   localparam int WB    = c2d_pkg::WEIGHT_BITS;
   localparam int PW    = SAMPLE_BITS + WB;        // one product
   localparam int RSW   = PW + 2;                  // sum of three products
   localparam int TSW   = PW + 4;                  // sum of nine products
   localparam int SUM_W = c2d_pkg::SUM_BITS;
   localparam int POS_W = c2d_pkg::POS_BITS;
   localparam int IWB   = c2d_pkg::IMAGE_WIDTH_BITS;
   localparam int DEPTH = c2d_pkg::OUT_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [IWB-1:0]                          image_width_ff;
   logic [c2d_pkg::KERNEL_ROW_BITS-1:0]     kernel_ff [KS];
   logic                                    csr_wr;
   logic                                    width_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign width_wr  = csr_wr &&
                      (c2d_pkg::csr_index_type'(csr_index) == c2d_pkg::CSR_IMAGE_WIDTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= c2d_pkg::IMAGE_WIDTH_RESET;
         for (int k = 0; k < KS; k++) begin
            kernel_ff[k] <= '0;
         end
      end else if (csr_wr) begin
         case (c2d_pkg::csr_index_type'(csr_index))
            c2d_pkg::CSR_IMAGE_WIDTH:   image_width_ff <= csr_data[IWB-1:0];
            c2d_pkg::CSR_KERNEL_TOP:    kernel_ff[0]   <= csr_data;
            c2d_pkg::CSR_KERNEL_MID:    kernel_ff[1]   <= csr_data;
            c2d_pkg::CSR_KERNEL_BOTTOM: kernel_ff[2]   <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp width into the supported range
   logic [CW-1:0] eff_w;
   logic [CW-1:0] w_m1;
   logic [CW-1:0] w_m2;

   always_comb begin
      if (int'(image_width_ff) < c2d_pkg::MIN_WIDTH) begin
         eff_w = CW'(c2d_pkg::MIN_WIDTH);
      end else if (int'(image_width_ff) > MAX_WIDTH) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = CW'(image_width_ff);
      end
   end

   assign w_m1 = eff_w - CW'(1);
   assign w_m2 = eff_w - CW'(2);

   // ------------------------------------------------------------------------
   // Sequencer: raster counters, end-of-frame flush, credit check
   // ------------------------------------------------------------------------
   c2d_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0]          row_ff, row_in;
   logic [CW-1:0]          col_ff, col_in;
   logic [CW-1:0]          fc_ff, fc_in;       // flush column

   logic                   s1_valid_ff;
   c2d_pkg::step_type      s1_step_ff;
   logic                   s2_valid_ff;
   logic                   s3_valid_ff;
   logic [CNT_W-1:0]       cnt_ff;

   logic [1:0]             inflight;
   logic [CNT_W:0]         occupancy;
   logic                   credit_ok;
   logic                   px_acc;
   logic                   step_go;
   logic                   is_last_px;

   // results that are on their way into the queue
   assign inflight  = 2'(s1_valid_ff && s1_step_ff.emit) + 2'(s2_valid_ff) + 2'(s3_valid_ff);
   assign occupancy = (CNT_W + 1)'(cnt_ff) + (CNT_W + 1)'(inflight);
   assign credit_ok = occupancy < (CNT_W + 1)'(DEPTH);

   assign req_stall  = (state_ff == c2d_pkg::SEQ_FLUSH) || !credit_ok;
   assign px_acc     = req_valid && !req_stall;
   assign step_go    = px_acc || ((state_ff == c2d_pkg::SEQ_FLUSH) && credit_ok);
   assign is_last_px = (row_ff == w_m1) && (col_ff == w_m1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c2d_pkg::SEQ_RUN;
         row_ff   <= '0;
         col_ff   <= '0;
         fc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         fc_ff    <= fc_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      fc_in    = fc_ff;
      case (state_ff)
         c2d_pkg::SEQ_RUN: begin
            if (px_acc) begin
               if (is_last_px) begin
                  row_in   = '0;
                  col_in   = '0;
                  fc_in    = '0;
                  state_in = c2d_pkg::SEQ_FLUSH;
               end else if (col_ff == w_m1) begin
                  col_in = '0;
                  row_in = row_ff + CW'(1);
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
         end
         c2d_pkg::SEQ_FLUSH: begin
            if (credit_ok) begin
               if (fc_ff == eff_w) begin
                  state_in = c2d_pkg::SEQ_RUN;
               end else begin
                  fc_in = fc_ff + CW'(1);
               end
            end
         end
         default: state_in = c2d_pkg::SEQ_RUN;
      endcase
      // a width write restarts the frame
      if (width_wr) begin
         row_in   = '0;
         col_in   = '0;
         state_in = c2d_pkg::SEQ_RUN;
      end
   end

   // ------------------------------------------------------------------------
   // Step decode. The flush first closes the right edge of the second-to-last
   // row, then replays the bottom of the frame as a virtual row (zero samples)
   // read back from the line store, plus one closing step for the bottom-right corner.
   // ------------------------------------------------------------------------
   c2d_pkg::step_type step;
   logic [CW-1:0]     orow;
   logic [CW-1:0]     ocol;
   logic [AW-1:0]     rd_addr;

   always_comb begin
      step = '0;
      orow = '0;
      ocol = '0;
      if (state_ff == c2d_pkg::SEQ_FLUSH) begin
         step.virt = 1'b1;
         step.emit = 1'b1;
         if (fc_ff == '0) begin
            // right edge of the second-to-last row
            orow            = w_m2;
            ocol            = w_m1;
            step.zero_third = 1'b1;
            step.col_start  = 1'b1;
         end else if (fc_ff == eff_w) begin
            // bottom-right corner closes the frame
            orow            = w_m1;
            ocol            = w_m1;
            step.zero_third = 1'b1;
            step.col_start  = 1'b1;
            step.run_last   = 1'b1;
            step.frame_last = 1'b1;
         end else begin
            orow = w_m1;
            ocol = fc_ff - CW'(1);
         end
      end else begin
         step.mem_write = 1'b1;
         step.run_last  = !is_last_px;
         if (col_ff == '0) begin
            // right edge of the row two above
            step.emit       = row_ff >= CW'(2);
            orow            = row_ff - CW'(2);
            ocol            = w_m1;
            step.zero_third = 1'b1;
            step.col_start  = 1'b1;
         end else begin
            step.emit = row_ff != '0;
            orow      = row_ff - CW'(1);
            ocol      = col_ff - CW'(1);
         end
      end
      step.top_clear = orow == '0;
      step.bot_clear = orow == w_m1;
      step.row       = POS_W'(orow);
      step.col       = POS_W'(ocol);
   end

   assign rd_addr = (state_ff == c2d_pkg::SEQ_FLUSH) ? fc_ff[AW-1:0] : col_ff[AW-1:0];

   // ------------------------------------------------------------------------
   // Line store: {row two above, row above} per column, read-modify-write.
   // Read issued with the step, written back in the next cycle at stage 1.
   // Consecutive steps of a frame hit different columns, so no forwarding is needed.
   // ------------------------------------------------------------------------
   logic [2*SAMPLE_BITS-1:0]        line_store [MAX_WIDTH];
   logic [2*SAMPLE_BITS-1:0]        rd_data_ff;
   logic [AW-1:0]                   s1_addr_ff;
   logic signed [SAMPLE_BITS-1:0]   s1_pixel_ff;
   logic signed [SAMPLE_BITS-1:0]   rd_two;
   logic signed [SAMPLE_BITS-1:0]   rd_above;
   logic                            mem_we;

   assign rd_two   = $signed(rd_data_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]);
   assign rd_above = $signed(rd_data_ff[SAMPLE_BITS-1:0]);
   assign mem_we   = s1_valid_ff && s1_step_ff.mem_write;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store[s1_addr_ff] <= {rd_above, s1_pixel_ff};
      end
      rd_data_ff <= line_store[rd_addr];
   end

   // stage 1 pipeline register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= step_go;
      end
   end

   always_ff @(posedge clock) begin
      s1_step_ff  <= step;
      s1_addr_ff  <= rd_addr;
      s1_pixel_ff <= req_pixel;
   end

   // ------------------------------------------------------------------------
   // Stage 1: window shift, padding masks, nine multiplies
   // ------------------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] col_vec    [KS];
   logic signed [SAMPLE_BITS-1:0] win_left_ff  [KS];
   logic signed [SAMPLE_BITS-1:0] win_right_ff [KS];
   logic signed [SAMPLE_BITS-1:0] samp [KS][KS];
   logic signed [WB-1:0]          wgt  [KS][KS];
   logic signed [PW-1:0]          prod_ff [KS][KS];
   c2d_pkg::pos_type              s2_pos_ff;

   always_comb begin
      col_vec[0] = rd_two;
      col_vec[1] = rd_above;
      col_vec[2] = s1_step_ff.virt ? '0 : s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || width_wr) begin
         for (int i = 0; i < KS; i++) begin
            win_left_ff[i]  <= '0;
            win_right_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         for (int i = 0; i < KS; i++) begin
            win_left_ff[i]  <= s1_step_ff.col_start ? '0 : win_right_ff[i];
            win_right_ff[i] <= col_vec[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < KS; i++) begin
         samp[i][0] = win_left_ff[i];
         samp[i][1] = win_right_ff[i];
         samp[i][2] = s1_step_ff.zero_third ? '0 : col_vec[i];
         // padding rows above the top and below the bottom
         if ((i == 0 && s1_step_ff.top_clear) || (i == KS - 1 && s1_step_ff.bot_clear)) begin
            for (int j = 0; j < KS; j++) begin
               samp[i][j] = '0;
            end
         end
         for (int j = 0; j < KS; j++) begin
            wgt[i][j] = $signed(kernel_ff[i][WB*j +: WB]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_step_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < KS; i++) begin
         for (int j = 0; j < KS; j++) begin
            prod_ff[i][j] <= samp[i][j] * wgt[i][j];
         end
      end
      s2_pos_ff.row        <= s1_step_ff.row;
      s2_pos_ff.col        <= s1_step_ff.col;
      s2_pos_ff.run_last   <= s1_step_ff.run_last;
      s2_pos_ff.frame_last <= s1_step_ff.frame_last;
   end

   // ------------------------------------------------------------------------
   // Stage 2: kernel row sums; stage 3: final sum
   // ------------------------------------------------------------------------
   logic signed [RSW-1:0] rsum [KS];
   logic signed [RSW-1:0] s3_rsum_ff [KS];
   c2d_pkg::pos_type      s3_pos_ff;
   logic signed [TSW-1:0] total;
   c2d_pkg::result_type   push_word;

   always_comb begin
      for (int i = 0; i < KS; i++) begin
         rsum[i] = RSW'(prod_ff[i][0]) + RSW'(prod_ff[i][1]) + RSW'(prod_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < KS; i++) begin
         s3_rsum_ff[i] <= rsum[i];
      end
      s3_pos_ff <= s2_pos_ff;
   end

   assign total = TSW'(s3_rsum_ff[0]) + TSW'(s3_rsum_ff[1]) + TSW'(s3_rsum_ff[2]);

   always_comb begin
      push_word.sum = SUM_W'(total);   // exact sum, kept to its low bits
      push_word.pos = s3_pos_ff;
   end

   // ------------------------------------------------------------------------
   // Output queue
   // ------------------------------------------------------------------------
   c2d_pkg::result_type out_fifo_ff [DEPTH];
   c2d_pkg::result_type head;
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic                push;
   logic                pop;

   assign push = s3_valid_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_fifo_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head           = out_fifo_ff[rd_ptr_ff];
   assign rsp_valid      = cnt_ff != '0;
   assign rsp_conv_sum   = head.sum;
   assign rsp_out_row    = head.pos.row;
   assign rsp_out_col    = head.pos.col;
   assign rsp_run_last   = head.pos.run_last;
   assign rsp_frame_last = head.pos.frame_last;

endmodule

`default_nettype wire

[rtl/core/c2d_checker.sv]
// ----------------------------------------------------------------------------
// c2d_checker
// Port-level checks on the result stream of the 3x3 convolution.
// ----------------------------------------------------------------------------
`default_nettype none

`include "conv2d_3x3_same_stream_defines.svh"

module c2d_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [c2d_pkg::SUM_BITS-1:0]        rsp_conv_sum,
   input wire logic [c2d_pkg::POS_BITS-1:0]        rsp_out_row,
   input wire logic [c2d_pkg::POS_BITS-1:0]        rsp_out_col,
   input wire logic                                rsp_run_last,
   input wire logic                                rsp_frame_last
);

   // stalled result word holds
   `C2D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_conv_sum) && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_run_last) && $stable(rsp_frame_last), "result word changed while stalled")

   // frame end is always the end of the run for the closing pixel
   `C2D_ASSERT_SAME(a_frame_run, clock, reset, rsp_valid && rsp_frame_last, rsp_run_last, "frame_last without run_last")

   // frame end sits on the bottom-right corner
   `C2D_ASSERT_SAME(a_frame_corner, clock, reset, rsp_valid && rsp_frame_last, rsp_out_row == rsp_out_col, "frame_last off the diagonal corner")

   // no result right out of reset
   `C2D_ASSERT_SAME(a_reset_quiet, clock, reset, $past(reset), !rsp_valid, "result word right after reset")

endmodule

bind conv2d_3x3_same_stream c2d_checker u_c2d_checker (.*);

`default_nettype wire

[dv/tb_conv2d_3x3_same_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_3x3_same_stream
// Self-checking bench for the streaming 3x3 same-size convolution.
// A scoreboard class tracks the line stores, window and frame position of the
// block and predicts every result word; the result side is checked against
// it word by word. Stimulus: a short directed part with extreme weights and
// samples, then random frames of mostly small widths, partial frames, kernel
// rewrites mid-frame, out-of-range widths, and a few rows at the largest width.
// ----------------------------------------------------------------------------

module tb_conv2d_3x3_same_stream;

   localparam int MAX_W          = 32;
   localparam int TOTAL_ITEMS    = 320;   // input words over the whole run
   localparam int WIDE_ITEMS     = 2 * MAX_W + 2;   // closing part at full width
   localparam int SETTLE_CYCLES  = 12;    // covers pipeline stages 1 to 3 and the queue, keep slack
   localparam int DRAIN_CYCLES   = 40;    // flush of a 32-wide row plus pipe
   localparam int HOLD_CYCLES    = 300;   // long result-side back pressure
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving
   localparam int REPORT_LIMIT   = 10;

   localparam int IWB   = c2d_pkg::IMAGE_WIDTH_BITS;
   localparam int KRB   = c2d_pkg::KERNEL_ROW_BITS;
   localparam int SUM_W = c2d_pkg::SUM_BITS;
   localparam int POS_W = c2d_pkg::POS_BITS;
   localparam int WGT_W = c2d_pkg::WEIGHT_BITS;
   localparam int MIN_W = c2d_pkg::MIN_WIDTH;
   localparam int CSR_W = c2d_pkg::CSR_INDEX_BITS;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts the result words and checks them in order
   // -------------------------------------------------------------------------
   class conv_scoreboard;
      logic [IWB-1:0]              width_reg;
      logic [KRB-1:0]              kern [3];
      logic signed [15:0]          back1 [MAX_W];   // row above
      logic signed [15:0]          back2 [MAX_W];   // row two above
      logic signed [15:0]          win [6];         // [0..2] left col, [3..5] mid col
      int                          col_pos;
      int                          row_pos;
      c2d_pkg::result_type         due_outputs [$];
      int                          failures;

      function new();
         width_reg = c2d_pkg::IMAGE_WIDTH_RESET;
         foreach (kern[i]) kern[i] = '0;
         foreach (back1[i]) begin
            back1[i] = '0;
            back2[i] = '0;
         end
         failures = 0;
         restart();
      endfunction

      function void restart();
         col_pos = 0;
         row_pos = 0;
         foreach (win[i]) win[i] = '0;
      endfunction

      function int active_width();
         int w;
         w = width_reg;
         if (w < MIN_W) w = MIN_W;
         if (w > MAX_W) w = MAX_W;
         return w;
      endfunction

      function int outstanding();
         return due_outputs.size();
      endfunction

      function void note_config(c2d_pkg::csr_index_type idx, logic [KRB-1:0] value);
         case (idx)
            c2d_pkg::CSR_IMAGE_WIDTH: begin
               width_reg = value[IWB-1:0];
               restart();
            end
            c2d_pkg::CSR_KERNEL_TOP:    kern[0] = value;
            c2d_pkg::CSR_KERNEL_MID:    kern[1] = value;
            c2d_pkg::CSR_KERNEL_BOTTOM: kern[2] = value;
            default: ;
         endcase
      endfunction

      // weighted 3x3 sum; padding rows cleared by output row
      function logic signed [SUM_W-1:0] patch_total(logic signed [15:0] s [3][3],
                                                    int orow, int w);
         longint             acc;
         logic signed [15:0] wgt;
         acc = 0;
         if (orow == 0) for (int j = 0; j < 3; j++) s[0][j] = '0;
         if (orow + 1 >= w) for (int j = 0; j < 3; j++) s[2][j] = '0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               wgt = $signed(kern[i][WGT_W*j +: WGT_W]);
               acc += longint'(wgt) * longint'(s[i][j]);
            end
         return acc[SUM_W-1:0];
      endfunction

      function logic signed [SUM_W-1:0] window_total(logic signed [15:0] third [3],
                                                     int orow, int w);
         logic signed [15:0] s [3][3];
         for (int i = 0; i < 3; i++) begin
            s[i][0] = win[i];
            s[i][1] = win[3+i];
            s[i][2] = third[i];
         end
         return patch_total(s, orow, w);
      endfunction

      function void queue_word(logic signed [SUM_W-1:0] total, int orow, int ocol,
                               bit frame_end);
         c2d_pkg::result_type word;
         word.sum            = total;
         word.pos.row        = POS_W'(orow);
         word.pos.col        = POS_W'(ocol);
         word.pos.run_last   = 1'b0;
         word.pos.frame_last = frame_end;
         due_outputs = {due_outputs, word};
      endfunction

      // one accepted pixel: advance the window, queue the sums it completes
      function void note_pixel(logic signed [15:0] x);
         int                 w;
         int                 r;
         int                 c;
         int                 cc;
         int                 start_depth;
         logic signed [15:0] colv [3];
         logic signed [15:0] zcol [3];
         logic signed [15:0] s [3][3];
         w = active_width();
         if (col_pos >= w || row_pos >= w) restart();
         r           = row_pos;
         c           = col_pos;
         start_depth = due_outputs.size();
         foreach (zcol[i]) zcol[i] = '0;

         colv[0]  = back2[c];
         colv[1]  = back1[c];
         colv[2]  = x;
         back2[c] = colv[1];
         back1[c] = x;

         if (c == 0) begin
            // column 0 closes the right-edge pixel two rows up
            if (r >= 2) queue_word(window_total(zcol, r - 2, w), r - 2, w - 1, 1'b0);
            for (int i = 0; i < 3; i++) begin
               win[i]   = '0;
               win[3+i] = colv[i];
            end
         end else begin
            if (r >= 1) queue_word(window_total(colv, r - 1, w), r - 1, c - 1, 1'b0);
            for (int i = 0; i < 3; i++) begin
               win[i]   = win[3+i];
               win[3+i] = colv[i];
            end
         end

         if (r == w - 1 && c == w - 1) begin
            // end of frame: last pixel of the row above, then the bottom row
            queue_word(window_total(zcol, w - 2, w), w - 2, w - 1, 1'b0);
            for (int oc = 0; oc < w; oc++) begin
               for (int d = -1; d <= 1; d++) begin
                  cc = oc + d;
                  if (cc >= 0 && cc < w) begin
                     s[0][d+1] = back2[cc];
                     s[1][d+1] = back1[cc];
                  end else begin
                     s[0][d+1] = '0;
                     s[1][d+1] = '0;
                  end
                  s[2][d+1] = '0;
               end
               queue_word(patch_total(s, w - 1, w), w - 1, oc, oc == w - 1);
            end
            restart();
         end else if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = r + 1;
         end else begin
            col_pos = c + 1;
         end

         if (due_outputs.size() > start_depth)
            due_outputs[due_outputs.size()-1].pos.run_last = 1'b1;
      endfunction

      function void check_result(logic signed [SUM_W-1:0] sum, logic [POS_W-1:0] row,
                                 logic [POS_W-1:0] col, logic run_last,
                                 logic frame_last);
         c2d_pkg::result_type want;
         if (due_outputs.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: result word with none due: sum %0d row %0d col %0d",
                        $realtime, sum, row, col);
            return;
         end
         want = due_outputs.pop_front();
         if (want.sum !== sum || want.pos.row !== row || want.pos.col !== col ||
             want.pos.run_last !== run_last || want.pos.frame_last !== frame_last) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("%0t: mismatch, want sum %0d row %0d col %0d last %b/%b",
                        $realtime, want.sum, want.pos.row, want.pos.col,
                        want.pos.run_last, want.pos.frame_last);
               $display("%0t:           got  sum %0d row %0d col %0d last %b/%b",
                        $realtime, sum, row, col, run_last, frame_last);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic clock;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [15:0]          req_pixel = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [SUM_W-1:0]     rsp_conv_sum;
   logic [POS_W-1:0]            rsp_out_row;
   logic [POS_W-1:0]            rsp_out_col;
   logic                        rsp_run_last;
   logic                        rsp_frame_last;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_W-1:0]            csr_index = '0;
   logic [KRB-1:0]              csr_data = '0;

   conv_scoreboard sb = new();

   int items_sent;    // input words accepted since the start
   bit steady;        // no idling on either side while set
   bit hold_request;  // asks the result side for a long stall

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   conv2d_3x3_same_stream u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_conv_sum   (rsp_conv_sum),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // -------------------------------------------------------------------------
   // Stimulus helpers. All sampling happens right at the rising edge, before
   // the nonblocking updates of that edge land, so we see pre-edge values.
   // -------------------------------------------------------------------------

   // half extremes and small values, the rest full range
   function automatic logic [15:0] rand_sample();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 12) return 16'h8000;
      if (pick < 24) return 16'h7fff;
      if (pick < 30) return 16'h0000;
      if (pick < 36) return 16'hffff;
      if (pick < 50) return 16'($urandom_range(64)) - 16'd32;
      return 16'($urandom);
   endfunction

   function automatic logic [KRB-1:0] rand_row();
      return {rand_sample(), rand_sample(), rand_sample()};
   endfunction

   task automatic write_reg(input c2d_pkg::csr_index_type idx, input logic [KRB-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.note_config(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // width write; upper data bits are don't-care, sometimes filled with noise
   task automatic write_width(input logic [IWB-1:0] code);
      logic [KRB-1:0] value;
      value = KRB'({$urandom, $urandom});
      if ($urandom_range(1)) value = '0;
      value[IWB-1:0] = code;
      write_reg(c2d_pkg::CSR_IMAGE_WIDTH, value);
   endtask

   // one input word; random gaps while valid is low, payload held while stalled
   task automatic send_pixel(input logic [15:0] value);
      while (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pixel(value);
      items_sent++;
      steady = items_sent >= 100 && items_sent < 180;
   endtask

   // stop sending, let every due word come out, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Result side: check accepted words, drive stall
   // -------------------------------------------------------------------------
   initial begin : result_side
      int hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_conv_sum, rsp_out_row, rsp_out_col, rsp_run_last,
                            rsp_frame_last);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (steady) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 35);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: ends the run if no word moves on any channel for too long
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d result words still due", $realtime,
                     sb.outstanding());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      c2d_pkg::csr_index_type kernel_regs [3] = '{c2d_pkg::CSR_KERNEL_TOP,
                                                  c2d_pkg::CSR_KERNEL_MID,
                                                  c2d_pkg::CSR_KERNEL_BOTTOM};
      logic [15:0] corner_values [9] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001,
                                         16'h5555, 16'haaaa, 16'h8000, 16'h7fff};
      logic [IWB-1:0] wcode;
      int pick;
      int eff;
      int count;
      int split;
      int budget;

      items_sent   = 0;
      steady       = 1'b0;
      hold_request = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---------------------------------------------------------
      // mixed extreme weights on a 3x3 image, all bits of the sample toggle
      write_reg(c2d_pkg::CSR_KERNEL_TOP,    {16'h0001, 16'h7fff, 16'h8000});
      write_reg(c2d_pkg::CSR_KERNEL_MID,    {16'h8000, 16'h0002, 16'hffff});
      write_reg(c2d_pkg::CSR_KERNEL_BOTTOM, {16'h8000, 16'hfffe, 16'h7fff});
      write_width(6'd3);
      foreach (corner_values[i]) send_pixel(corner_values[i]);
      settle();

      // most negative weights times most negative samples: largest sum
      foreach (kernel_regs[i]) write_reg(kernel_regs[i], {3{16'h8000}});
      repeat (9) send_pixel(16'h8000);
      settle();

      // width below range acts as 3; early pixels only, then a restart
      write_width(6'd0);
      repeat (4) send_pixel(rand_sample());
      settle();

      // --- back pressure: result side stalls long while input keeps coming ---
      write_width(6'd8);
      foreach (kernel_regs[i]) write_reg(kernel_regs[i], rand_row());
      hold_request = 1'b1;
      repeat (64) send_pixel(rand_sample());
      settle();

      // --- random frames, mostly small ----------------------------------------
      while (items_sent < TOTAL_ITEMS - WIDE_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 60)      wcode = 6'($urandom_range(6, 3));
         else if (pick < 80) wcode = 6'($urandom_range(12, 7));
         else if (pick < 90) wcode = 6'($urandom_range(2, 0));
         else                wcode = 6'($urandom_range(63, 32));
         eff = int'(wcode) < MIN_W ? MIN_W : (int'(wcode) > MAX_W ? MAX_W : int'(wcode));

         foreach (kernel_regs[i])
            if ($urandom_range(1)) write_reg(kernel_regs[i], rand_row());
         write_width(wcode);

         if (eff > 12)                    count = int'($urandom_range(3 * eff, 1));
         else if ($urandom_range(3) == 0) count = int'($urandom_range(eff * eff - 1, 1));
         else                             count = eff * eff * int'($urandom_range(2, 1));
         // keep the run near its item budget
         budget = TOTAL_ITEMS - WIDE_ITEMS - items_sent;
         if (count > budget) count = budget;
         // sometimes pause inside the frame and swap one kernel row
         split = ($urandom_range(3) == 0) ? int'($urandom_range(count - 1, 0)) : -1;

         for (int k = 0; k < count; k++) begin
            if (k == split && k > 0) begin
               settle();
               write_reg(kernel_regs[$urandom_range(2)], rand_row());
            end
            send_pixel(rand_sample());
         end
         settle();
      end

      // --- two rows and a bit at the largest width ---------------------------
      foreach (kernel_regs[i]) write_reg(kernel_regs[i], rand_row());
      write_width(6'd32);
      repeat (WIDE_ITEMS) send_pixel(rand_sample());

      // --- wind down ---------------------------------------------------------
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
